// ===== src/wat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekday alarm table package
// Shared types, command and status codes for the alarm table block.
// ----------------------------------------------------------------------------
package wat_pkg;

   localparam int unsigned DEF_MAX_ENTRIES = 16;

   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_REMOVE = 3'd1;
   localparam logic [2:0] ACT_UPDATE = 3'd2;
   localparam logic [2:0] ACT_MATCH  = 3'd3;
   localparam logic [2:0] ACT_READ   = 3'd4;
   localparam logic [2:0] ACT_TAKE   = 3'd5;
   localparam logic [2:0] ACT_CLEAR  = 3'd6;
   localparam logic [2:0] ACT_UNUSED = 3'd7;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_DUP  = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   localparam logic [2:0] WEEKDAY_NONE = 3'd7;
   localparam logic [7:0] ID_RESET     = 8'd1;

   typedef struct packed {
      logic [7:0] entry_id;
      logic       enabled;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [6:0] day_mask;
      logic [7:0] brightness;
      logic [7:0] fade_minutes;
      logic       one_time;
      logic       skip_next;
   } entry_type;

   typedef struct packed {
      logic [2:0] action;
      entry_type  entry;
      logic [2:0] weekday;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      entry_type  entry;
      logic       last;
      logic [6:0] entry_count;
   } rsp_type;

   function automatic entry_type entry_zero();
      entry_type e;
      e = '0;
      return e;
   endfunction

endpackage : wat_pkg
`default_nettype wire

// ===== src/wat_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekday alarm table channel
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface wat_req_if;
   import wat_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface : wat_req_if

interface wat_rsp_if;
   import wat_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface : wat_rsp_if
`default_nettype wire

// ===== src/wat_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekday alarm table entry memory
// Simple dual-port synchronous entry store (one write port, one read port) with a registered read.
// ----------------------------------------------------------------------------
module wat_mem #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire wat_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output wat_pkg::entry_type      rd_data
);
   import wat_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule : wat_mem
`default_nettype wire

// ===== src/wat_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekday alarm table sequencer
// Scans entries in table order, one per cycle unless a match hit waits on the
// result channel; performs lookups, compaction on remove, and result beats.
// ----------------------------------------------------------------------------
module wat_ctrl #(
   parameter int unsigned MAX_ENTRIES = 16,
   parameter int unsigned AW = 4,
   parameter int unsigned CW = 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   wat_req_if.sink                 req,
   wat_rsp_if.source               rsp,
   output logic                    mem_wr_en,
   output logic [AW-1:0]           mem_wr_addr,
   output wat_pkg::entry_type      mem_wr_data,
   output logic [AW-1:0]           mem_rd_addr,
   input  wire wat_pkg::entry_type mem_rd_data,
   output logic [CW-1:0]           used_count
);
   import wat_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_EMIT  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

   state_type       state_ff, state_in;
   req_type         cmd_ff, cmd_in;
   logic [CW-1:0]   used_ff, used_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            pend_ff, pend_in;
   logic [7:0]      idc_ff, idc_in;
   logic            found_ff, found_in;
   logic            hit_ff, hit_in;
   logic            dup_ff, dup_in;
   logic [CW-1:0]   pos_ff, pos_in;
   entry_type       sav_ff, sav_in;
   logic            rv_ff, rv_in;
   rsp_type         rd_ff, rd_in;

   logic            out_free, rd_match, rd_dupe, rd_idhit, last_rd;
   entry_type       cur;

   assign cur = cmd_ff.entry;
   assign out_free = !rv_ff || rsp.ready;
   assign rd_idhit = mem_rd_data.entry_id == cur.entry_id;
   assign rd_dupe = mem_rd_data.hour == cur.hour && mem_rd_data.minute == cur.minute
      && mem_rd_data.day_mask == cur.day_mask;
   assign rd_match = mem_rd_data.enabled && mem_rd_data.hour == cur.hour
      && mem_rd_data.minute == cur.minute && cmd_ff.weekday != WEEKDAY_NONE
      && mem_rd_data.day_mask[cmd_ff.weekday] == 1'b1;
   assign last_rd = idx_ff + CW'(1) >= used_ff;

   assign req.ready = state_ff == S_IDLE;
   assign rsp.valid = rv_ff;
   assign rsp.data = rd_ff;
   assign used_count = used_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      used_in = used_ff;
      idx_in = idx_ff;
      pend_in = 1'b0;
      idc_in = idc_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      dup_in = dup_ff;
      pos_in = pos_ff;
      sav_in = sav_ff;
      rv_in = rv_ff && !rsp.ready;
      rd_in = rd_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = cur;
      mem_rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.data;
               idx_in = '0;
               found_in = 1'b0;
               hit_in = 1'b0;
               dup_in = 1'b0;
               pend_in = used_ff != '0;
               mem_rd_addr = '0;
               state_in = used_ff != '0 ? S_SCAN : S_DONE;
               if (req.data.action == ACT_TAKE || req.data.action == ACT_CLEAR
                     || req.data.action > ACT_CLEAR) begin
                  state_in = S_DONE;
                  pend_in = 1'b0;
               end
            end
         end
         S_SCAN: begin
            // pend_ff marks that mem_rd_data holds entry idx_ff.
            if (!pend_ff) begin
               pend_in = 1'b1;
            end else if (cmd_ff.action == ACT_MATCH && rd_match && hit_ff
                  && !out_free) begin
               pend_in = 1'b1;
            end else begin
               if (cmd_ff.action == ACT_ADD && rd_dupe) dup_in = 1'b1;
               // A hit is held back until the next hit or the end of the scan,
               // so the final beat of a match can carry last.
               if (cmd_ff.action == ACT_MATCH && rd_match) begin
                  if (hit_ff) begin
                     rv_in = 1'b1;
                     rd_in.status = ST_OK;
                     rd_in.entry = sav_ff;
                     rd_in.last = 1'b0;
                     rd_in.entry_count = 7'(used_ff);
                  end
                  hit_in = 1'b1;
                  sav_in = mem_rd_data;
               end
               if ((cmd_ff.action == ACT_REMOVE || cmd_ff.action == ACT_UPDATE
                     || cmd_ff.action == ACT_READ) && rd_idhit) begin
                  found_in = 1'b1;
                  pos_in = idx_ff;
                  sav_in = mem_rd_data;
                  state_in = S_DONE;
               end
               if (state_in != S_DONE) begin
                  if (last_rd) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in = idx_ff + CW'(1);
                     mem_rd_addr = idx_in[AW-1:0];
                     pend_in = 1'b1;
                  end
               end
            end
            if (!pend_in && state_in == S_SCAN) mem_rd_addr = idx_ff[AW-1:0];
         end
         S_SHIFT: begin
            // Entry idx_ff+1 is on the read port; move it down one place.
            if (!pend_ff) begin
               pend_in = 1'b1;
            end else begin
               mem_wr_en = 1'b1;
               mem_wr_addr = idx_ff[AW-1:0];
               mem_wr_data = mem_rd_data;
               idx_in = idx_ff + CW'(1);
               if (idx_ff + CW'(2) >= used_ff) begin
                  state_in = S_EMIT;
               end else begin
                  mem_rd_addr = AW'(idx_ff + CW'(2));
                  pend_in = 1'b1;
               end
            end
            if (!pend_in && state_in == S_SHIFT) mem_rd_addr = AW'(idx_ff + CW'(1));
         end
         S_EMIT: begin
            if (out_free) begin
               rv_in = 1'b1;
               rd_in.status = ST_OK;
               rd_in.entry = sav_ff;
               rd_in.last = 1'b1;
               rd_in.entry_count = 7'(used_ff - CW'(1));
               used_in = used_ff - CW'(1);
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (cmd_ff.action == ACT_REMOVE && found_ff
                  && pos_ff + CW'(1) < used_ff) begin
               idx_in = pos_ff;
               mem_rd_addr = AW'(pos_ff + CW'(1));
               pend_in = 1'b1;
               state_in = S_SHIFT;
            end else if (out_free) begin
               rv_in = 1'b1;
               rd_in.status = ST_OK;
               rd_in.entry = entry_zero();
               rd_in.last = 1'b1;
               state_in = S_IDLE;
               case (cmd_ff.action)
                  ACT_ADD: begin
                     if (used_ff >= MAX_CNT) begin
                        rd_in.status = ST_FULL;
                     end else if (dup_ff) begin
                        rd_in.status = ST_DUP;
                     end else begin
                        mem_wr_en = 1'b1;
                        mem_wr_addr = used_ff[AW-1:0];
                        used_in = used_ff + CW'(1);
                        rd_in.entry = cur;
                        if (cur.entry_id >= idc_ff) idc_in = cur.entry_id + 8'd1;
                     end
                  end
                  ACT_REMOVE: begin
                     if (found_ff) begin
                        rd_in.entry = sav_ff;
                        used_in = used_ff - CW'(1);
                     end else begin
                        rd_in.status = ST_NONE;
                     end
                  end
                  ACT_UPDATE: begin
                     if (found_ff) begin
                        mem_wr_en = 1'b1;
                        mem_wr_addr = pos_ff[AW-1:0];
                        rd_in.entry = cur;
                     end else begin
                        rd_in.status = ST_NONE;
                     end
                  end
                  ACT_READ: begin
                     if (found_ff) rd_in.entry = sav_ff;
                     else rd_in.status = ST_NONE;
                  end
                  ACT_MATCH: begin
                     if (hit_ff) rd_in.entry = sav_ff;
                     else rd_in.status = ST_NONE;
                  end
                  ACT_TAKE: begin
                     rd_in.entry.entry_id = idc_ff;
                     idc_in = idc_ff + 8'd1;
                  end
                  ACT_CLEAR: begin
                     used_in = '0;
                     idc_in = ID_RESET;
                  end
                  default: begin
                  end
               endcase
               rd_in.entry_count = 7'(used_in);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         idc_ff <= ID_RESET;
         rv_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         idc_ff <= idc_in;
         rv_ff <= rv_in;
         pend_ff <= pend_in;
      end
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      found_ff <= found_in;
      hit_ff <= hit_in;
      dup_ff <= dup_in;
      pos_ff <= pos_in;
      sav_ff <= sav_in;
      rd_ff <= rd_in;
   end

endmodule : wat_ctrl
`default_nettype wire

// ===== src/weekday_alarm_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Lookups stop at the first id hit; next-id and clear skip the scan and go
// straight to the done state. Remove moves each later entry down one place
// before it answers; output stalls delay the answer.
// One command at a time: a new request is taken only in the idle state.
// Match holds each hit until the next hit or the scan end so the final beat can carry last.
// Reset: synchronous; clears the entry count, sets the next-id counter to 1.
// ----------------------------------------------------------------------------
// Weekday alarm table
// Ordered alarm entry table with add, remove, update, match, read, next-id
// and clear commands over valid/ready channels.
// ----------------------------------------------------------------------------
module weekday_alarm_table #(
   parameter int unsigned MAX_ENTRIES = wat_pkg::DEF_MAX_ENTRIES
) (
   input  wire logic clock,
   input  wire logic reset,
   wat_req_if.sink   req,
   wat_rsp_if.source rsp
);
   import wat_pkg::*;

   localparam int unsigned AW = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1) + 1;

   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr, mem_rd_addr;
   entry_type       mem_wr_data, mem_rd_data;
   logic [CW-1:0]   used_count;

   wat_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   wat_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .AW(AW), .CW(CW)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .used_count  (used_count)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count <= CW'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid)
      else $error("result beat dropped");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> {1'b0, mem_wr_addr} < {1'b0, AW'(MAX_ENTRIES - 1)} + 1'b1
         || MAX_ENTRIES >= (1 << AW))
      else $error("memory write out of range");

endmodule : weekday_alarm_table
`default_nettype wire
